>>> rtl/core/envelope_balance_gain_top_assert.svh
// ----------------------------------------------------------------------------
// envelope_balance_gain_top_assert.svh
// Assertion macros for the envelope balance gain block
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_BALANCE_GAIN_TOP_ASSERT_SVH
`define ENVELOPE_BALANCE_GAIN_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication on clk, off during rst
`define EBG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("envelope_balance_gain_top: check failed");
// next-cycle implication on clk, off during rst
`define EBG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("envelope_balance_gain_top: check failed");
`else
`define EBG_ASSERT_IMP(label, ante, cons)
`define EBG_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/core/ebg_pkg.sv
// ----------------------------------------------------------------------------
// ebg_pkg
// Shared widths and constants of the envelope balance gain block
// ----------------------------------------------------------------------------
`default_nettype none

package ebg_pkg;

  // sample and envelope widths
  localparam int SAMPLE_WIDTH   = 16;
  localparam int ENVELOPE_WIDTH = 24;

  // smoother pole, Q0.16
  localparam int                  COEF_WIDTH = 16;
  localparam logic [COEF_WIDTH-1:0] COEF_RESET = 16'd65240;

  // fraction bits of the gain
  localparam int GAIN_FRAC = 16;

endpackage

`default_nettype wire

>>> rtl/core/ebg_in_if.sv
// ----------------------------------------------------------------------------
// ebg_in_if
// Input channel: signal and reference sample pair with block-end marker
// ----------------------------------------------------------------------------
`default_nettype none

interface ebg_in_if #(
  parameter int SampleWidth = ebg_pkg::SAMPLE_WIDTH
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] signal_sample;
  logic signed [SampleWidth-1:0] reference_sample;
  logic                          last_of_block;

  modport source (
    output valid, signal_sample, reference_sample, last_of_block,
    input  ready
  );

  modport sink (
    input  valid, signal_sample, reference_sample, last_of_block,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/core/ebg_out_if.sv
// ----------------------------------------------------------------------------
// ebg_out_if
// Output channel: balanced sample with clip flag and block-end marker
// ----------------------------------------------------------------------------
`default_nettype none

interface ebg_out_if #(
  parameter int SampleWidth = ebg_pkg::SAMPLE_WIDTH
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] balanced_sample;
  logic                          saturated;
  logic                          last_out;

  modport source (
    output valid, balanced_sample, saturated, last_out,
    input  ready
  );

  modport sink (
    input  valid, balanced_sample, saturated, last_out,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/core/envelope_balance_gain_top.sv
// Flow: an accepted beat runs both smoothers, the divider, the gain products and the
//   hand-off; the fractional product and final step are skipped when the sample is
//   zero or the gain alone already clips. No new beat is taken until the result is
//   handed off; the restoring divider retires one quotient bit per cycle (EnvelopeWidth + 16 steps).
// Reset (rst, synchronous): envelopes cleared, smoothing coefficient back to 65240,
//   sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// envelope_balance_gain_top
// Rectify and smooth a signal and a reference, scale the signal by the ratio
// of the two envelopes, saturate; one shared multiplier and a serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module envelope_balance_gain_top #(
  parameter int SampleWidth   = ebg_pkg::SAMPLE_WIDTH,
  parameter int EnvelopeWidth = ebg_pkg::ENVELOPE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ebg_pkg::COEF_WIDTH-1:0]  cfg_wr_data,
  ebg_in_if.sink                          sample_ch,
  ebg_out_if.source                       result_ch
);

  import ebg_pkg::*;

  `include "envelope_balance_gain_top_assert.svh"

  // derived widths
  localparam int ScaleUp   = (EnvelopeWidth >= SampleWidth) ? EnvelopeWidth - SampleWidth : 0;
  localparam int ScaleDown = (SampleWidth > EnvelopeWidth) ? SampleWidth - EnvelopeWidth : 0;
  localparam int MulAW     = (EnvelopeWidth > SampleWidth) ? EnvelopeWidth : SampleWidth;
  localparam int MulBW     = (SampleWidth > COEF_WIDTH + 1) ? SampleWidth : COEF_WIDTH + 1;
  localparam int AccW      = MulAW + MulBW + 1;
  localparam int QuoW      = EnvelopeWidth + GAIN_FRAC;
  localparam int CntW      = $clog2(QuoW);

  localparam logic [COEF_WIDTH:0]      CoefOne   = {1'b1, {COEF_WIDTH{1'b0}}};
  localparam logic [AccW-1:0]          RoundHalf = AccW'(1) << (COEF_WIDTH - 1);
  localparam logic [EnvelopeWidth-1:0] EnvOne    = EnvelopeWidth'(1) << (EnvelopeWidth - 1);
  localparam logic [SampleWidth-1:0]   PosMax    = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic [SampleWidth-1:0]   NegMag    = {1'b1, {(SampleWidth-1){1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SE1  = 11'b000_0000_0010,
    S_SE2  = 11'b000_0000_0100,
    S_SE3  = 11'b000_0000_1000,
    S_RE2  = 11'b000_0001_0000,
    S_RE3  = 11'b000_0010_0000,
    S_DIV  = 11'b000_0100_0000,
    S_MHI  = 11'b000_1000_0000,
    S_MLO  = 11'b001_0000_0000,
    S_FIN  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  // magnitude of a two's complement sample
  function automatic logic [SampleWidth-1:0] abs_val(input logic [SampleWidth-1:0] v);
    return v[SampleWidth-1] ? (~v + SampleWidth'(1)) : v;
  endfunction

  // magnitude to envelope scale, 1.0 at the top envelope bit
  function automatic logic [EnvelopeWidth-1:0] to_env(input logic [SampleWidth-1:0] m);
    logic [SampleWidth+EnvelopeWidth-1:0] w;
    w = ((SampleWidth + EnvelopeWidth)'(m) << ScaleUp) >> ScaleDown;
    return w[EnvelopeWidth-1:0];
  endfunction

  state_t                   state;
  logic [COEF_WIDTH-1:0]    coef;
  logic [EnvelopeWidth-1:0] sig_env;
  logic [EnvelopeWidth-1:0] ref_env;
  logic                     out_valid;

  logic [SampleWidth-1:0]   sig_mag;
  logic [EnvelopeWidth-1:0] sig_mag_e;
  logic [EnvelopeWidth-1:0] ref_mag_e;
  logic                     sig_neg;
  logic                     last_r;

  logic [MulAW-1:0]         mul_a;
  logic [MulBW-1:0]         mul_b;
  logic [MulAW+MulBW-1:0]   mul_p;
  logic [AccW-1:0]          acc;

  logic [QuoW-1:0]          quo;
  logic [EnvelopeWidth:0]   rem;
  logic [EnvelopeWidth-1:0] dvs;
  logic [CntW-1:0]          cnt;

  logic [SampleWidth-1:0]   res_sample;
  logic                     res_sat;
  logic [SampleWidth-1:0]   out_sample;
  logic                     out_sat;
  logic                     out_last;

  logic                     in_beat;
  logic                     out_free;
  logic [AccW-1:0]          sum_w;
  logic [EnvelopeWidth-1:0] env_new;
  logic [EnvelopeWidth:0]   trial;
  logic                     fits;
  logic [EnvelopeWidth:0]   rem_step;
  logic [EnvelopeWidth-1:0] gain_hi;
  logic [GAIN_FRAC-1:0]     gain_lo;
  logic [SampleWidth-1:0]   lim;
  logic                     gh_over;
  logic [AccW-1:0]          prod_w;
  logic                     prod_over;
  logic [SampleWidth-1:0]   fin_mag;
  logic                     fin_sat;
  logic [SampleWidth-1:0]   fin_res;

  // handshakes
  assign in_beat         = sample_ch.valid && sample_ch.ready;
  assign out_free        = !out_valid || result_ch.ready;
  assign sample_ch.ready = (state == S_IDLE);

  assign result_ch.valid           = out_valid;
  assign result_ch.balanced_sample = out_sample;
  assign result_ch.saturated       = out_sat;
  assign result_ch.last_out        = out_last;

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_SE1: begin
        mul_a = MulAW'(sig_mag_e);
        mul_b = MulBW'(CoefOne - {1'b0, coef});
      end
      S_SE2: begin
        mul_a = MulAW'(sig_env);
        mul_b = MulBW'(coef);
      end
      S_SE3: begin
        mul_a = MulAW'(ref_mag_e);
        mul_b = MulBW'(CoefOne - {1'b0, coef});
      end
      S_RE2: begin
        mul_a = MulAW'(ref_env);
        mul_b = MulBW'(coef);
      end
      S_MHI: begin
        mul_a = MulAW'(sig_mag);
        mul_b = MulBW'(gain_hi);
      end
      S_MLO: begin
        mul_a = MulAW'(sig_mag);
        mul_b = MulBW'(gain_lo);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // smoother sum, rounded and scaled back
  assign sum_w   = acc + AccW'(mul_p);
  assign env_new = sum_w[EnvelopeWidth+COEF_WIDTH-1:COEF_WIDTH];

  // restoring divider step
  assign trial    = {rem[EnvelopeWidth-1:0], quo[QuoW-1]};
  assign fits     = (trial >= {1'b0, dvs});
  assign rem_step = fits ? (trial - {1'b0, dvs}) : trial;

  // gain split and clip limit
  assign gain_hi = quo[QuoW-1:GAIN_FRAC];
  assign gain_lo = quo[GAIN_FRAC-1:0];
  assign lim     = sig_neg ? NegMag : PosMax;
  assign gh_over = (MulAW'(gain_hi) > MulAW'(lim));

  // integer part product plus fractional part product
  assign prod_w    = acc + AccW'(mul_p >> GAIN_FRAC);
  assign prod_over = (prod_w > AccW'(lim));

  // final magnitude, clip flag and sign
  always_comb begin
    if (state == S_MHI) begin
      if (sig_mag == '0) begin
        fin_mag = '0;
        fin_sat = 1'b0;
      end else begin
        fin_mag = lim;
        fin_sat = 1'b1;
      end
    end else if (prod_over) begin
      fin_mag = lim;
      fin_sat = 1'b1;
    end else begin
      fin_mag = prod_w[SampleWidth-1:0];
      fin_sat = 1'b0;
    end
    fin_res = sig_neg ? (~fin_mag + SampleWidth'(1)) : fin_mag;
  end

  // sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      coef      <= COEF_RESET;
      sig_env   <= '0;
      ref_env   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        coef <= cfg_wr_data;
      end
      // result register: a new result wins over the drain of the old one
      priority if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (result_ch.valid && result_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_ch.valid) begin
            state <= S_SE1;
          end
        end
        S_SE1: state <= S_SE2;
        S_SE2: state <= S_SE3;
        S_SE3: begin
          sig_env <= env_new;
          state   <= S_RE2;
        end
        S_RE2: state <= S_RE3;
        S_RE3: begin
          ref_env <= env_new;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_MHI;
          end
        end
        S_MHI: begin
          if (sig_mag == '0 || gh_over) begin
            state <= S_OUT;
          end else begin
            state <= S_MLO;
          end
        end
        S_MLO: state <= S_FIN;
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        if (in_beat) begin
          sig_mag   <= abs_val(sample_ch.signal_sample);
          sig_mag_e <= to_env(abs_val(sample_ch.signal_sample));
          ref_mag_e <= to_env(abs_val(sample_ch.reference_sample));
          sig_neg   <= sample_ch.signal_sample[SampleWidth-1];
          last_r    <= sample_ch.last_of_block;
        end
      end
      S_SE2, S_RE2: begin
        acc <= AccW'(mul_p) + RoundHalf;
      end
      S_RE3: begin
        quo <= {env_new, {GAIN_FRAC{1'b0}}};
        rem <= '0;
        dvs <= (sig_env == '0) ? EnvOne : sig_env;
        cnt <= CntW'(QuoW - 1);
      end
      S_DIV: begin
        quo <= {quo[QuoW-2:0], fits};
        rem <= rem_step;
        cnt <= cnt - CntW'(1);
      end
      S_MHI, S_FIN: begin
        res_sample <= fin_res;
        res_sat    <= fin_sat;
      end
      S_MLO: begin
        acc <= AccW'(mul_p);
      end
      S_OUT: begin
        if (out_free) begin
          out_sample <= res_sample;
          out_sat    <= res_sat;
          out_last   <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

  // a beat starts the signal smoother right away
  `EBG_ASSERT_NXT(a_beat_starts, in_beat, state == S_SE1)
  // a new result appears only from the hand-off state
  `EBG_ASSERT_IMP(a_valid_from_out, $rose(result_ch.valid), $past(state == S_OUT))
  // after the last divider step the remainder is below the divisor
  `EBG_ASSERT_IMP(a_div_rem, state == S_MHI, rem < (EnvelopeWidth + 1)'(dvs))
  // a clipped result sits at one of the two bounds
  `EBG_ASSERT_IMP(a_sat_bound, result_ch.valid && result_ch.saturated, (out_sample == PosMax) || (out_sample == NegMag))

endmodule

`default_nettype wire

>>> sim/ebg_balance_checker.sv
// ----------------------------------------------------------------------------
// ebg_balance_checker
// Watches the sample and result channels and the coefficient port, predicts
// each balanced sample from its own envelope state and compares in order
// ----------------------------------------------------------------------------
module ebg_balance_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ebg_pkg::COEF_WIDTH-1:0] cfg_wr_data,
  ebg_in_if                              sample_ch,
  ebg_out_if                             result_ch,
  output int unsigned                    fail_count,
  output int unsigned                    pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import ebg_pkg::*;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [ENVELOPE_WIDTH-1:0]      env_t;
  typedef logic [COEF_WIDTH-1:0]          coef_t;

  typedef struct packed {
    sample_t balanced;
    logic    saturated;
    logic    last;
  } balanced_beat_t;

  localparam longint unsigned COEF_ONE  = 64'd1 << COEF_WIDTH;
  localparam longint unsigned UNITY_ENV = 64'd1 << (ENVELOPE_WIDTH - 1);
  localparam longint unsigned GAIN_MASK = (64'd1 << GAIN_FRAC) - 64'd1;
  localparam longint unsigned POS_MAX   = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;

  coef_t          smooth_k;
  env_t           signal_env;
  env_t           reference_env;
  balanced_beat_t balanced_q[$];
  int unsigned    mismatches = 0;

  // rectified sample on the envelope scale
  function automatic env_t rectified_level(sample_t s);
    longint signed   sv;
    longint unsigned mag;
    longint unsigned lvl;
    sv  = s;
    mag = (sv < 0) ? -sv : sv;
    lvl = mag << (ENVELOPE_WIDTH - SAMPLE_WIDTH);
    return lvl[ENVELOPE_WIDTH-1:0];
  endfunction

  // one-pole smoother, rounded
  function automatic env_t smooth_envelope(env_t env, env_t level, coef_t k);
    longint unsigned acc;
    acc = 64'(level) * (COEF_ONE - 64'(k)) + 64'(env) * 64'(k) + (COEF_ONE >> 1);
    acc = acc >> COEF_WIDTH;
    return acc[ENVELOPE_WIDTH-1:0];
  endfunction

  // envelope ratio gain applied to the signal, saturated
  function automatic balanced_beat_t balance_sample(sample_t s, env_t s_env, env_t r_env,
                                                     logic last);
    longint signed   sv;
    longint unsigned smag, div, gain, gh, gl, lim, prod, res;
    balanced_beat_t  beat;
    sv   = s;
    smag = (sv < 0) ? -sv : sv;
    div  = (s_env == '0) ? UNITY_ENV : 64'(s_env);
    gain = (64'(r_env) << GAIN_FRAC) / div;
    gh   = gain >> GAIN_FRAC;
    gl   = gain & GAIN_MASK;
    lim  = (sv < 0) ? POS_MAX + 64'd1 : POS_MAX;
    beat.saturated = 1'b0;
    if (smag == 0) begin
      prod = 0;
    end else if (gh > lim) begin
      prod = lim;
      beat.saturated = 1'b1;
    end else begin
      prod = smag * gh + ((smag * gl) >> GAIN_FRAC);
      if (prod > lim) begin
        prod = lim;
        beat.saturated = 1'b1;
      end
    end
    res = (sv < 0) ? 64'd0 - prod : prod;
    beat.balanced = res[SAMPLE_WIDTH-1:0];
    beat.last     = last;
    return beat;
  endfunction

  // compare results, track coefficient writes, predict accepted samples
  always @(posedge clk) begin
    balanced_beat_t want;
    if (rst) begin
      smooth_k      = COEF_RESET;
      signal_env    = '0;
      reference_env = '0;
      balanced_q.delete();
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (balanced_q.size() == 0) begin
          $display("%0t: unexpected result beat, balanced_sample %0d", $time,
                   result_ch.balanced_sample);
          mismatches++;
        end else begin
          want = balanced_q.pop_front();
          if (result_ch.balanced_sample !== want.balanced) begin
            $display("%0t: balanced_sample expected %0d actual %0d", $time,
                     want.balanced, result_ch.balanced_sample);
            mismatches++;
          end
          if (result_ch.saturated !== want.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time,
                     want.saturated, result_ch.saturated);
            mismatches++;
          end
          if (result_ch.last_out !== want.last) begin
            $display("%0t: last_out expected %0b actual %0b", $time,
                     want.last, result_ch.last_out);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) smooth_k = cfg_wr_data;
      if (sample_ch.valid && sample_ch.ready) begin
        signal_env    = smooth_envelope(signal_env,
                                        rectified_level(sample_ch.signal_sample), smooth_k);
        reference_env = smooth_envelope(reference_env,
                                        rectified_level(sample_ch.reference_sample), smooth_k);
        balanced_q.push_back(balance_sample(sample_ch.signal_sample, signal_env,
                                            reference_env, sample_ch.last_of_block));
      end
    end
    fail_count    <= mismatches;
    pending_count <= balanced_q.size();
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Envelope balance gain testbench: directed corner samples, then random
// blocks of samples at varied levels under several smoothing coefficients and
// valid/ready idling patterns; the checker predicts and compares each beat
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ebg_pkg::*;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [COEF_WIDTH-1:0]          coef_t;

  localparam sample_t     SAMPLE_MAX     = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t     SAMPLE_MIN     = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam coef_t       COEF_MAX       = '1;
  localparam coef_t       COEF_HALF      = coef_t'(1) << (COEF_WIDTH - 1);
  localparam int unsigned LATENCY        = ENVELOPE_WIDTH + 25;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 192;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  coef_t       cfg_wr_data;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned idle_cycles;

  ebg_in_if  sample_ch ();
  ebg_out_if result_ch ();

  envelope_balance_gain_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample_ch   (sample_ch),
    .result_ch   (result_ch)
  );

  ebg_balance_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .sample_ch     (sample_ch),
    .result_ch     (result_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result ready with random stalls
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_ch.valid && sample_ch.ready) ||
          (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[envelope_balance_gain_top] ERROR");
    $finish;
  end

  // random sample at a level set by the shift; full shift gives silence
  function automatic sample_t level_sample(int unsigned shift);
    logic [31:0] raw;
    sample_t     v;
    raw = $urandom;
    v   = raw[SAMPLE_WIDTH-1:0];
    if (shift >= SAMPLE_WIDTH) return '0;
    case ($urandom_range(31))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      default: return v >>> shift;
    endcase
  endfunction

  // one sample beat, with a random lead-in gap
  task automatic send_beat(input sample_t sig, input sample_t refsmp, input logic last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (sender_idle_pct != 0 && $urandom_range(7) == 0) gap += $urandom_range(1, 70);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid            <= 1'b1;
    sample_ch.signal_sample    <= sig;
    sample_ch.reference_sample <= refsmp;
    sample_ch.last_of_block    <= last;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_coef(input coef_t k);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // blocks of samples with independent signal and reference levels
  task automatic send_random_blocks(input int unsigned count);
    int unsigned sent, len, sig_shift, ref_shift;
    logic        last;
    sent = 0;
    while (sent < count) begin
      len       = $urandom_range(1, 24);
      sig_shift = $urandom_range(0, SAMPLE_WIDTH);
      ref_shift = $urandom_range(0, SAMPLE_WIDTH);
      for (int i = 0; i < len && sent < count; i++) begin
        last = (i == len - 1) ^ ($urandom_range(15) == 0);
        send_beat(level_sample(sig_shift), level_sample(ref_shift), last);
        sent++;
      end
      if ($urandom_range(63) == 0) drain_results();
    end
  endtask

  // stimulus
  initial begin
    coef_t k;
    rst                        <= 1'b1;
    cfg_wr_en                  <= 1'b0;
    cfg_wr_data                <= '0;
    sample_ch.valid            <= 1'b0;
    sample_ch.signal_sample    <= '0;
    sample_ch.reference_sample <= '0;
    sample_ch.last_of_block    <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficient, envelopes start at zero so the divisor is unity
    send_beat('0, '0, 1'b0);
    send_beat('0, SAMPLE_MAX, 1'b1);
    send_beat(16'sd1, SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    send_beat(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_beat(-16'sd1, '0, 1'b0);
    send_beat(16'sd1, SAMPLE_MIN, 1'b0);

    // no smoothing: huge gains clip, unity gain on the most negative sample
    write_coef('0);
    send_beat(16'sd1, SAMPLE_MAX, 1'b1);
    send_beat(-16'sd1, SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_beat(-16'sd2, SAMPLE_MAX, 1'b0);
    send_beat(16'sd12345, -16'sd12345, 1'b1);
    send_beat('0, '0, 1'b0);

    // slowest pole from zero envelopes: a small signal sample leaves the signal envelope at zero
    write_coef(COEF_MAX);
    send_beat(16'sd100, SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_beat(SAMPLE_MAX, '0, 1'b0);

    // random phases over coefficients and idling patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       k = COEF_RESET;
        1:       k = '0;
        2:       k = COEF_MAX;
        3:       k = COEF_HALF;
        5:       k = coef_t'(1);
        6:       k = coef_t'(65000);
        default: k = coef_t'($urandom_range(1, 65534));
      endcase
      case (p % 4)
        0:       begin sender_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1:       begin sender_idle_pct <= 51; recv_stall_pct <= 0;  end
        2:       begin sender_idle_pct <= 0;  recv_stall_pct <= 51; end
        default: begin sender_idle_pct <= 19; recv_stall_pct <= 19; end
      endcase
      write_coef(k);
      send_random_blocks(PHASE_ITEMS);
    end

    drain_results();
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("[envelope_balance_gain_top] OK");
    else
      $display("[envelope_balance_gain_top] ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ebg_pkg.sv
rtl/core/ebg_in_if.sv
rtl/core/ebg_out_if.sv
rtl/core/envelope_balance_gain_top.sv
sim/ebg_balance_checker.sv
sim/tb.sv
